FILE: src/byte_pretokenizer_split_core_assert.svh
// Assertion macros shared by the splitter modules.
`ifndef BYTE_PRETOKENIZER_SPLIT_CORE_ASSERT_SVH
`define BYTE_PRETOKENIZER_SPLIT_CORE_ASSERT_SVH

// Checked only while out of reset.
`define BPTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked during reset as well.
`define BPTS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: src/bpts_pkg.sv
package bpts_pkg;

    // Character constants
    localparam logic [7:0] APOS_CH   = 8'h27;
    localparam logic [7:0] LETTER_HI = 8'h80;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_V      = 8'h76;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_S      = 8'h73;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_D      = 8'h64;
    localparam logic [7:0] CH_M      = 8'h6D;

    // Most results one byte can release
    localparam int GRP_MAX = 3;

    typedef enum logic [2:0] {
        RC_NONE   = 3'd0,
        RC_LETTER = 3'd1,
        RC_DIGIT  = 3'd2,
        RC_OTHER  = 3'd3,
        RC_WS     = 3'd4,
        RC_APOS   = 3'd5
    } run_class_t;

    // Splitter state: held bytes, open run and chunk-start flag
    typedef struct packed {
        logic [1:0] cnt;
        run_class_t cls;
        logic [7:0] h0;
        logic [7:0] h1;
        logic       acs;
    } state_t;

    localparam state_t ST_RESET = '{cnt: 2'd0, cls: RC_NONE, h0: 8'h00, h1: 8'h00,
                                    acs: 1'b1};

    typedef struct packed {
        logic [7:0] byte_val;
        logic       first;
        logic       last;
        logic       seg;
    } res_t;

    // Results released by one byte, oldest in entry 0
    typedef struct packed {
        logic [1:0]             cnt;
        res_t [GRP_MAX-1:0]     res;
    } grp_t;

    function automatic res_t make_res(input logic [7:0] b, input logic f,
                                      input logic l, input logic s);
        res_t r;
        r.byte_val = b;
        r.first    = f;
        r.last     = l;
        r.seg      = s;
        return r;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) ||
               (c == 8'h0D) || (c == 8'h0C) || (c == 8'h0B);
    endfunction

    function automatic logic digit_ch(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic letter_ch(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               (c >= LETTER_HI);
    endfunction

    function automatic logic is_other(input logic [7:0] c);
        return !is_ws(c) && !letter_ch(c) && !digit_ch(c);
    endfunction

    function automatic run_class_t class_of(input logic [7:0] c);
        if (letter_ch(c)) return RC_LETTER;
        if (digit_ch(c)) return RC_DIGIT;
        return RC_OTHER;
    endfunction

    // Class of a run opened by c at a chunk start
    function automatic run_class_t class_start(input logic [7:0] c);
        if (c == APOS_CH) return RC_APOS;
        if (is_ws(c)) return RC_WS;
        return class_of(c);
    endfunction

    function automatic logic short_suffix(input logic [7:0] a);
        return (a == CH_S) || (a == CH_T) || (a == CH_D) || (a == CH_M);
    endfunction

    function automatic logic long_lead(input logic [7:0] a);
        return (a == CH_L) || (a == CH_V) || (a == CH_R);
    endfunction

    function automatic logic long_match(input logic [7:0] a, input logic [7:0] b);
        return ((a == CH_L) && (b == CH_L)) || ((a == CH_V) && (b == CH_E)) ||
               ((a == CH_R) && (b == CH_E));
    endfunction

endpackage

FILE: src/bpts_step.sv
// Chunk decision for one byte: results released and the next splitter state.
module bpts_step (
    input  logic [7:0]       c,
    input  logic             last,
    input  bpts_pkg::state_t st,
    output bpts_pkg::state_t st_next,
    output bpts_pkg::grp_t   grp
);

    logic [1:0]                           n;
    bpts_pkg::res_t [bpts_pkg::GRP_MAX-1:0] res;
    logic                                 sb;
    logic                                 jn;
    bpts_pkg::run_class_t                 cs;

    always_comb begin
        n       = 2'd0;
        res     = '0;
        st_next = st;
        sb      = 1'b0;
        jn      = bpts_pkg::short_suffix(c) || bpts_pkg::is_other(c);
        cs      = bpts_pkg::class_start(c);

        if ((st.cnt == 2'd0) || (st.cnt == 2'd3)) begin
            sb = 1'b1;
        end else begin
            unique case (st.cls) inside
                // whitespace run
                bpts_pkg::RC_WS: begin
                    if (bpts_pkg::is_ws(c)) begin
                        if (last) begin
                            res[n] = bpts_pkg::make_res(st.h0, st.acs, 1'b0, 1'b0);
                            n = n + 2'd1;
                            if (st.cnt == 2'd2) begin
                                res[n] = bpts_pkg::make_res(st.h1, 1'b0, 1'b0, 1'b0);
                                n = n + 2'd1;
                            end
                            res[n] = bpts_pkg::make_res(c, 1'b0, 1'b1, 1'b1);
                            n = n + 2'd1;
                            st_next.cnt = 2'd0;
                            st_next.cls = bpts_pkg::RC_NONE;
                            st_next.acs = 1'b1;
                        end else if (st.cnt == 2'd1) begin
                            st_next.h1  = c;
                            st_next.cnt = 2'd2;
                        end else begin
                            res[n] = bpts_pkg::make_res(st.h0, st.acs, 1'b0, 1'b0);
                            n = n + 2'd1;
                            st_next.h0  = st.h1;
                            st_next.h1  = c;
                            st_next.acs = 1'b0;
                        end
                    end else begin
                        // last space moves onto the next run as its prefix
                        if (st.cnt == 2'd2) begin
                            res[n] = bpts_pkg::make_res(st.h0, st.acs, 1'b1, 1'b0);
                            n = n + 2'd1;
                            res[n] = bpts_pkg::make_res(st.h1, 1'b1, 1'b0, 1'b0);
                            n = n + 2'd1;
                        end else begin
                            res[n] = bpts_pkg::make_res(st.h0, 1'b1, 1'b0, 1'b0);
                            n = n + 2'd1;
                        end
                        if (last) begin
                            res[n] = bpts_pkg::make_res(c, 1'b0, 1'b1, 1'b1);
                            n = n + 2'd1;
                            st_next.cnt = 2'd0;
                            st_next.cls = bpts_pkg::RC_NONE;
                            st_next.acs = 1'b1;
                        end else begin
                            st_next.h0  = c;
                            st_next.cnt = 2'd1;
                            st_next.cls = bpts_pkg::class_of(c);
                            st_next.acs = 1'b0;
                        end
                    end
                end
                // apostrophe held at a chunk start
                bpts_pkg::RC_APOS: begin
                    if (st.cnt == 2'd1) begin
                        if (last) begin
                            res[n] = bpts_pkg::make_res(bpts_pkg::APOS_CH, 1'b1, !jn, 1'b0);
                            n = n + 2'd1;
                            res[n] = bpts_pkg::make_res(c, !jn, 1'b1, 1'b1);
                            n = n + 2'd1;
                            st_next.cnt = 2'd0;
                            st_next.cls = bpts_pkg::RC_NONE;
                            st_next.acs = 1'b1;
                        end else if (bpts_pkg::long_lead(c)) begin
                            st_next.h1  = c;
                            st_next.cnt = 2'd2;
                        end else if (bpts_pkg::short_suffix(c)) begin
                            res[n] = bpts_pkg::make_res(bpts_pkg::APOS_CH, 1'b1, 1'b0, 1'b0);
                            n = n + 2'd1;
                            res[n] = bpts_pkg::make_res(c, 1'b0, 1'b1, 1'b0);
                            n = n + 2'd1;
                            st_next.cnt = 2'd0;
                            st_next.cls = bpts_pkg::RC_NONE;
                            st_next.acs = 1'b1;
                        end else if (bpts_pkg::is_other(c)) begin
                            res[n] = bpts_pkg::make_res(bpts_pkg::APOS_CH, 1'b1, 1'b0, 1'b0);
                            n = n + 2'd1;
                            st_next.h0  = c;
                            st_next.cnt = 2'd1;
                            st_next.cls = bpts_pkg::RC_OTHER;
                            st_next.acs = 1'b0;
                        end else begin
                            res[n] = bpts_pkg::make_res(bpts_pkg::APOS_CH, 1'b1, 1'b1, 1'b0);
                            n = n + 2'd1;
                            sb = 1'b1;
                        end
                    end else if (bpts_pkg::long_match(st.h1, c)) begin
                        res[n] = bpts_pkg::make_res(bpts_pkg::APOS_CH, 1'b1, 1'b0, 1'b0);
                        n = n + 2'd1;
                        res[n] = bpts_pkg::make_res(st.h1, 1'b0, 1'b0, 1'b0);
                        n = n + 2'd1;
                        res[n] = bpts_pkg::make_res(c, 1'b0, 1'b1, last);
                        n = n + 2'd1;
                        st_next.cnt = 2'd0;
                        st_next.cls = bpts_pkg::RC_NONE;
                        st_next.acs = 1'b1;
                    end else begin
                        // no contraction: lead opens a word or stands alone
                        res[n] = bpts_pkg::make_res(bpts_pkg::APOS_CH, 1'b1, 1'b1, 1'b0);
                        n = n + 2'd1;
                        if (bpts_pkg::letter_ch(c)) begin
                            res[n] = bpts_pkg::make_res(st.h1, 1'b1, 1'b0, 1'b0);
                            n = n + 2'd1;
                            if (last) begin
                                res[n] = bpts_pkg::make_res(c, 1'b0, 1'b1, 1'b1);
                                n = n + 2'd1;
                                st_next.cnt = 2'd0;
                                st_next.cls = bpts_pkg::RC_NONE;
                                st_next.acs = 1'b1;
                            end else begin
                                st_next.h0  = c;
                                st_next.cnt = 2'd1;
                                st_next.cls = bpts_pkg::RC_LETTER;
                                st_next.acs = 1'b0;
                            end
                        end else begin
                            res[n] = bpts_pkg::make_res(st.h1, 1'b1, 1'b1, 1'b0);
                            n = n + 2'd1;
                            sb = 1'b1;
                        end
                    end
                end
                // letter, digit or symbol run
                bpts_pkg::RC_LETTER, bpts_pkg::RC_DIGIT, bpts_pkg::RC_OTHER: begin
                    if (((st.cls == bpts_pkg::RC_LETTER) && bpts_pkg::letter_ch(c)) ||
                        ((st.cls == bpts_pkg::RC_DIGIT) && bpts_pkg::digit_ch(c)) ||
                        ((st.cls == bpts_pkg::RC_OTHER) && bpts_pkg::is_other(c))) begin
                        res[n] = bpts_pkg::make_res(st.h0, st.acs, 1'b0, 1'b0);
                        n = n + 2'd1;
                        if (last) begin
                            res[n] = bpts_pkg::make_res(c, 1'b0, 1'b1, 1'b1);
                            n = n + 2'd1;
                            st_next.cnt = 2'd0;
                            st_next.cls = bpts_pkg::RC_NONE;
                            st_next.acs = 1'b1;
                        end else begin
                            st_next.h0  = c;
                            st_next.cnt = 2'd1;
                            st_next.acs = 1'b0;
                        end
                    end else begin
                        res[n] = bpts_pkg::make_res(st.h0, st.acs, 1'b1, 1'b0);
                        n = n + 2'd1;
                        sb = 1'b1;
                    end
                end
                default: begin
                    sb = 1'b1;
                end
            endcase
        end

        // byte opens a fresh chunk with nothing held
        if (sb) begin
            if (last) begin
                res[n] = bpts_pkg::make_res(c, 1'b1, 1'b1, 1'b1);
                n = n + 2'd1;
                st_next.cnt = 2'd0;
                st_next.cls = bpts_pkg::RC_NONE;
                st_next.acs = 1'b1;
            end else begin
                st_next.h0  = c;
                st_next.cnt = 2'd1;
                st_next.cls = cs;
                st_next.acs = 1'b1;
            end
        end

        grp.cnt = n;
        grp.res = res;
    end

endmodule

FILE: src/bpts_out.sv
`include "byte_pretokenizer_split_core_assert.svh"

// Result group register: holds one byte's results and hands them out in order.
module bpts_out (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           load_en,
    input  bpts_pkg::grp_t load_grp,
    output logic           can_load,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,   // out_byte
    output logic [2:0]     m_tuser,   // chunk_first, chunk_last, group_last
    output logic           m_tlast    // seg_end
);

    logic [1:0]                             cnt_reg, cnt_next;
    logic [1:0]                             idx_reg, idx_next;
    bpts_pkg::res_t [bpts_pkg::GRP_MAX-1:0] res_reg;
    bpts_pkg::res_t                         cur;
    logic                                   take;
    logic                                   at_end;
    logic                                   done;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign take     = m_tvalid && m_tready;
    assign at_end   = (idx_reg == (cnt_reg - 2'd1));
    assign done     = take && at_end;
    assign can_load = !m_tvalid || done;
    assign cur      = res_reg[idx_reg];

    assign m_tdata = cur.byte_val;
    assign m_tuser = {at_end, cur.last, cur.first};
    assign m_tlast = cur.seg;

    // group count and read pointer
    always_comb begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load_en) begin
            cnt_next = load_grp.cnt;
            idx_next = 2'd0;
        end else if (done) begin
            cnt_next = 2'd0;
            idx_next = 2'd0;
        end else if (take) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (load_en) begin
            res_reg <= load_grp.res;
        end
    end

    `BPTS_ASSERT(a_idx_in_group, m_tvalid |-> (idx_reg < cnt_reg), "read pointer past group")
    `BPTS_ASSERT(a_load_when_free, load_en |-> can_load, "group loaded while results pending")
    `BPTS_ASSERT_RST(a_reset_empty, !aresetn |=> !m_tvalid, "results shown after reset")

endmodule

FILE: src/byte_pretokenizer_split_core.sv
// Channel | Dir | tdata      | tuser                                 | tlast
// s_      | in  | in_byte    | -                                     | in_seg_last
// m_      | out | out_byte   | chunk_first, chunk_last, group_last   | seg_end
//
// A transaction on s_ releases 0 to 3 results on m_, one per cycle while m_tready is
// high; a byte per cycle is taken while each gives at most one result and m_ keeps up.
// The first result of an input transaction reaches m_ through two registers in turn:
// the input register, then the result group register.
// Two or three results stall s_tready when a byte waits behind; so does m_tready low.
// aresetn is synchronous, active low; held bytes are dropped, no clearing pass.
`include "byte_pretokenizer_split_core_assert.svh"

module byte_pretokenizer_split_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic       s_tlast,   // in_seg_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte
    output logic [2:0] m_tuser,   // chunk_first, chunk_last, group_last
    output logic       m_tlast    // seg_end
);

    logic             in_vld_reg, in_vld_next;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;
    bpts_pkg::state_t st_reg, st_next;
    bpts_pkg::grp_t   grp;
    logic             can_load;
    logic             proc;
    logic             two_held_ok;
    logic             idle_ok;

    // byte in the input register moves on when the group register is free
    assign proc     = in_vld_reg && can_load;
    assign s_tready = !in_vld_reg || proc;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_tvalid && s_tready) begin
            in_vld_next = 1'b1;
        end else if (proc) begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            st_reg     <= bpts_pkg::ST_RESET;
        end else begin
            in_vld_reg <= in_vld_next;
            if (proc) begin
                st_reg <= st_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    bpts_step u_step (
        .c       (in_byte_reg),
        .last    (in_last_reg),
        .st      (st_reg),
        .st_next (st_next),
        .grp     (grp)
    );

    bpts_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load_en  (proc),
        .load_grp (grp),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // state invariants
    assign two_held_ok = (st_reg.cnt != 2'd2) || (st_reg.cls == bpts_pkg::RC_WS) ||
                         (st_reg.cls == bpts_pkg::RC_APOS);
    assign idle_ok     = (st_reg.cls != bpts_pkg::RC_NONE) ||
                         (st_reg.acs && (st_reg.cnt == 2'd0));

    `BPTS_ASSERT(a_hold_depth, st_reg.cnt != 2'd3, "more than two bytes held")
    `BPTS_ASSERT(a_two_held_kind, two_held_ok, "two bytes held outside space or apostrophe run")
    `BPTS_ASSERT(a_idle_starts, idle_ok, "idle state without chunk start")

endmodule

FILE: tb/byte_pretokenizer_split_core_tb.sv
`timescale 1ns / 100ps

module byte_pretokenizer_split_core_tb;

    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_ITEMS = 500;
    localparam int MAX_REPORTS  = 10;

    // One released byte with its chunk flags
    typedef struct packed {
        logic [7:0] text;
        logic       chunk_first;
        logic       chunk_last;
        logic       seg_end;
        logic       group_last;
    } chunk_res_t;

    // One input byte; typed rows carry their single result written out by hand
    typedef struct packed {
        logic [7:0] text;
        logic       seg_last;
        logic       typed;
        chunk_res_t want;
    } feed_row_t;

    localparam logic [7:0] BLANKS [6] = '{8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0C, 8'h0B};

    // Directed bytes: extremes, the contractions 's 'll 've 're, the segment-end cases
    localparam int N_DIRECTED = 26;
    localparam feed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{8'h00,             1'b1, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1, 1'b1}}, // lone byte
        '{8'hFF,             1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b1, 1'b1}}, // top byte
        '{bpts_pkg::APOS_CH, 1'b0, 1'b0, '0},
        '{"s",               1'b0, 1'b0, '0},                               // 's
        '{bpts_pkg::APOS_CH, 1'b0, 1'b0, '0},
        '{"l",               1'b0, 1'b0, '0},
        '{"l",               1'b0, 1'b0, '0},                               // 'll
        '{bpts_pkg::APOS_CH, 1'b0, 1'b0, '0},
        '{"v",               1'b0, 1'b0, '0},
        '{"e",               1'b0, 1'b0, '0},                               // 've
        '{bpts_pkg::APOS_CH, 1'b0, 1'b0, '0},
        '{"r",               1'b0, 1'b0, '0},
        '{"e",               1'b1, 1'b0, '0},                               // 're at end
        '{bpts_pkg::APOS_CH, 1'b0, 1'b0, '0},
        '{"l",               1'b1, 1'b0, '0},                               // 'l cut off
        '{bpts_pkg::APOS_CH, 1'b0, 1'b0, '0},
        '{"x",               1'b0, 1'b0, '0},                               // no contraction
        '{"!",               1'b0, 1'b0, '0},
        '{bpts_pkg::APOS_CH, 1'b0, 1'b0, '0},                               // inside symbols
        '{"d",               1'b0, 1'b0, '0},
        '{" ",               1'b0, 1'b0, '0},
        '{"\t",              1'b0, 1'b0, '0},
        '{" ",               1'b0, 1'b0, '0},
        '{"7",               1'b0, 1'b0, '0},                               // prefixed digit
        '{" ",               1'b0, 1'b0, '0},
        '{"\n",              1'b1, 1'b0, '0}                                // blanks to end
    };

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic       m_tlast;

    feed_row_t  feed[$];
    chunk_res_t pending_chunks[$];
    chunk_res_t step_out[$];
    int         fault_cnt = 0;
    int         cycle_cnt = 0;

    // Splitter state mirrored by the predictor
    logic [7:0]           held [2];
    logic [1:0]           held_cnt;
    bpts_pkg::run_class_t cur_class;
    logic                 prefixed;
    logic                 chunk_open;

    byte_pretokenizer_split_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),     // in_byte
        .s_tlast  (s_tlast),     // in_seg_last
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),     // out_byte
        .m_tuser  (m_tuser),     // chunk_first, chunk_last, group_last
        .m_tlast  (m_tlast)      // seg_end
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Byte classes
    function automatic logic blank_byte(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D || c == 8'h0C || c == 8'h0B;
    endfunction

    function automatic logic digit_byte(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic alpha_byte(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c[7];
    endfunction

    function automatic logic symbol_byte(input logic [7:0] c);
        return !blank_byte(c) && !alpha_byte(c) && !digit_byte(c);
    endfunction

    function automatic bpts_pkg::run_class_t word_class(input logic [7:0] c);
        if (alpha_byte(c)) return bpts_pkg::RC_LETTER;
        if (digit_byte(c)) return bpts_pkg::RC_DIGIT;
        return bpts_pkg::RC_OTHER;
    endfunction

    function automatic logic same_class(input logic [7:0] c, input bpts_pkg::run_class_t cls);
        case (cls)
            bpts_pkg::RC_LETTER: return alpha_byte(c);
            bpts_pkg::RC_DIGIT:  return digit_byte(c);
            default:             return symbol_byte(c);
        endcase
    endfunction

    function automatic logic short_tail(input logic [7:0] c);
        return c == bpts_pkg::CH_S || c == bpts_pkg::CH_T || c == bpts_pkg::CH_D ||
               c == bpts_pkg::CH_M;
    endfunction

    task automatic release_byte(input logic [7:0] b, input logic f, input logic l,
                                input logic s);
        chunk_res_t r;
        r = '{b, f, l, s, 1'b0};
        step_out.insert(step_out.size(), r);
    endtask

    task automatic clear_run();
        held_cnt   = 2'd0;
        cur_class  = bpts_pkg::RC_NONE;
        prefixed   = 1'b0;
        chunk_open = 1'b1;
    endtask

    task automatic hold(input logic [7:0] c, input bpts_pkg::run_class_t cls, input logic f,
                        input logic pre);
        held[0]    = c;
        held_cnt   = 2'd1;
        cur_class  = cls;
        chunk_open = f;
        prefixed   = pre;
    endtask

    // Byte arriving at a chunk start with nothing held
    task automatic open_byte(input logic [7:0] c, input logic at_end);
        if (at_end) begin
            release_byte(c, 1'b1, 1'b1, 1'b1);
            clear_run();
        end else if (c == bpts_pkg::APOS_CH) begin
            hold(c, bpts_pkg::RC_APOS, 1'b1, 1'b0);
        end else if (blank_byte(c)) begin
            hold(c, bpts_pkg::RC_WS, 1'b1, 1'b0);
        end else begin
            hold(c, word_class(c), 1'b1, 1'b0);
        end
    endtask

    // Single blank w in front of the run opened by c
    task automatic open_prefixed(input logic [7:0] w, input logic [7:0] c,
                                 input logic at_end);
        release_byte(w, 1'b1, 1'b0, 1'b0);
        if (at_end) begin
            release_byte(c, 1'b0, 1'b1, 1'b1);
            clear_run();
        end else begin
            hold(c, word_class(c), 1'b0, 1'b1);
        end
    endtask

    // Letter, digit or symbol run open, latest byte held
    task automatic run_step(input logic [7:0] c, input logic at_end);
        logic [7:0] h;
        logic       f;
        h = held[0];
        f = chunk_open;
        if (same_class(c, cur_class)) begin
            release_byte(h, f, 1'b0, 1'b0);
            if (at_end) begin
                release_byte(c, 1'b0, 1'b1, 1'b1);
                clear_run();
            end else begin
                hold(c, cur_class, 1'b0, prefixed);
            end
        end else begin
            release_byte(h, f, 1'b1, 1'b0);
            clear_run();
            open_byte(c, at_end);
        end
    endtask

    // Predict the results of one accepted byte into step_out
    task automatic split_byte(input logic [7:0] c, input logic at_end);
        logic       f;
        logic       oth;
        logic [7:0] a;
        step_out.delete();
        f = chunk_open;
        if (held_cnt == 2'd0 || cur_class == bpts_pkg::RC_NONE) begin
            clear_run();
            open_byte(c, at_end);
        end else if (cur_class == bpts_pkg::RC_WS) begin
            if (blank_byte(c)) begin
                if (at_end) begin
                    release_byte(held[0], f, 1'b0, 1'b0);
                    if (held_cnt == 2'd2) release_byte(held[1], 1'b0, 1'b0, 1'b0);
                    release_byte(c, 1'b0, 1'b1, 1'b1);
                    clear_run();
                end else if (held_cnt == 2'd1) begin
                    held[1]  = c;
                    held_cnt = 2'd2;
                end else begin
                    // keep the two newest blanks, the oldest goes out
                    release_byte(held[0], f, 1'b0, 1'b0);
                    held[0]    = held[1];
                    held[1]    = c;
                    chunk_open = 1'b0;
                end
            end else if (held_cnt == 2'd2) begin
                a = held[1];
                release_byte(held[0], f, 1'b1, 1'b0);
                open_prefixed(a, c, at_end);
            end else begin
                open_prefixed(held[0], c, at_end);
            end
        end else if (cur_class == bpts_pkg::RC_APOS) begin
            if (held_cnt == 2'd1) begin
                if (at_end) begin
                    if (short_tail(c)) begin
                        release_byte(bpts_pkg::APOS_CH, 1'b1, 1'b0, 1'b0);
                        release_byte(c, 1'b0, 1'b1, 1'b1);
                    end else begin
                        oth = symbol_byte(c);
                        release_byte(bpts_pkg::APOS_CH, 1'b1, !oth, 1'b0);
                        release_byte(c, !oth, 1'b1, 1'b1);
                    end
                    clear_run();
                end else if (c == bpts_pkg::CH_L || c == bpts_pkg::CH_V ||
                             c == bpts_pkg::CH_R) begin
                    held[1]  = c;
                    held_cnt = 2'd2;
                end else if (short_tail(c)) begin
                    release_byte(bpts_pkg::APOS_CH, 1'b1, 1'b0, 1'b0);
                    release_byte(c, 1'b0, 1'b1, 1'b0);
                    clear_run();
                end else if (symbol_byte(c)) begin
                    release_byte(bpts_pkg::APOS_CH, 1'b1, 1'b0, 1'b0);
                    hold(c, bpts_pkg::RC_OTHER, 1'b0, 1'b0);
                end else begin
                    release_byte(bpts_pkg::APOS_CH, 1'b1, 1'b1, 1'b0);
                    clear_run();
                    open_byte(c, 1'b0);
                end
            end else begin
                a = held[1];
                if ((a == bpts_pkg::CH_L && c == bpts_pkg::CH_L) ||
                    (a == bpts_pkg::CH_V && c == bpts_pkg::CH_E) ||
                    (a == bpts_pkg::CH_R && c == bpts_pkg::CH_E)) begin
                    release_byte(bpts_pkg::APOS_CH, 1'b1, 1'b0, 1'b0);
                    release_byte(a, 1'b0, 1'b0, 1'b0);
                    release_byte(c, 1'b0, 1'b1, at_end);
                    clear_run();
                end else begin
                    // no two-letter suffix: apostrophe stands alone, lead opens a word
                    release_byte(bpts_pkg::APOS_CH, 1'b1, 1'b1, 1'b0);
                    hold(a, bpts_pkg::RC_LETTER, 1'b1, 1'b0);
                    run_step(c, at_end);
                end
            end
        end else begin
            run_step(c, at_end);
        end
        if (step_out.size() > 0) step_out[step_out.size() - 1].group_last = 1'b1;
    endtask

    // Result side: check each transaction, stall on a changing pattern
    logic [7:0] stall_pat = 8'hFF;
    int         pat_left  = 0;
    logic [2:0] pat_pos   = 3'd0;

    always @(posedge aclk) begin
        chunk_res_t got;
        chunk_res_t exp_res;
        got = '{m_tdata, m_tuser[0], m_tuser[1], m_tlast, m_tuser[2]};
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_chunks.size() == 0) begin
                fault_cnt++;
                if (fault_cnt <= MAX_REPORTS)
                    $display("unexpected result: byte %02h first %b last %b seg %b grp %b",
                             got.text, got.chunk_first, got.chunk_last, got.seg_end,
                             got.group_last);
            end else begin
                exp_res = pending_chunks.pop_front();
                if (got !== exp_res) begin
                    fault_cnt++;
                    // flags shown as first, last, seg, grp
                    if (fault_cnt <= MAX_REPORTS)
                        $display("mismatch: exp %02h %b%b%b%b, got %02h %b%b%b%b",
                                 exp_res.text, exp_res.chunk_first, exp_res.chunk_last,
                                 exp_res.seg_end, exp_res.group_last, got.text,
                                 got.chunk_first, got.chunk_last, got.seg_end,
                                 got.group_last);
                end
            end
        end
        if (pat_left == 0) begin
            pat_left  = $urandom_range(8, 80);
            stall_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(1, 255));
        end
        pat_left--;
        m_tready <= stall_pat[pat_pos];
        pat_pos  = pat_pos + 3'd1;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int         idx;
        int         burst_left;
        int         gap_left;
        int         seg_len;
        int         rand_items;
        int         n;
        logic [7:0] b;
        logic [7:0] text_q[$];
        logic [7:0] piece[$];
        feed_row_t  row;

        held[0] = 8'h00;
        held[1] = 8'h00;
        clear_run();

        for (int i = 0; i < N_DIRECTED; i++) feed.insert(feed.size(), DIRECTED_ROWS[i]);

        // Random segments built mostly from well-formed pieces, cut at a random length
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            seg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 12);
            text_q.delete();
            while (text_q.size() < seg_len) begin
                piece.delete();
                case ($urandom_range(0, 11)) inside
                    [0:2]: begin
                        n = $urandom_range(1, 6);
                        repeat (n) begin
                            case ($urandom_range(0, 2))
                                0:       b = 8'($urandom_range(8'h61, 8'h7A));
                                1:       b = 8'($urandom_range(8'h41, 8'h5A));
                                default: b = 8'($urandom_range(8'h80, 8'hFF));
                            endcase
                            piece.insert(piece.size(), b);
                        end
                    end
                    3: begin
                        n = $urandom_range(1, 4);
                        repeat (n) piece.insert(piece.size(), 8'($urandom_range(8'h30, 8'h39)));
                    end
                    4: begin
                        n = $urandom_range(1, 3);
                        repeat (n) begin
                            do b = 8'($urandom_range(0, 8'h7F)); while (!symbol_byte(b));
                            piece.insert(piece.size(), b);
                        end
                    end
                    [5:6]: begin
                        n = $urandom_range(1, 4);
                        repeat (n) piece.insert(piece.size(), BLANKS[$urandom_range(0, 5)]);
                    end
                    [7:8]: begin
                        piece.insert(piece.size(), bpts_pkg::APOS_CH);
                        case ($urandom_range(0, 9))
                            0: piece.insert(piece.size(), bpts_pkg::CH_S);
                            1: piece.insert(piece.size(), bpts_pkg::CH_T);
                            2: piece.insert(piece.size(), bpts_pkg::CH_D);
                            3: piece.insert(piece.size(), bpts_pkg::CH_M);
                            4: begin
                                piece.insert(piece.size(), bpts_pkg::CH_L);
                                piece.insert(piece.size(), bpts_pkg::CH_L);
                            end
                            5: begin
                                piece.insert(piece.size(), bpts_pkg::CH_V);
                                piece.insert(piece.size(), bpts_pkg::CH_E);
                            end
                            6: begin
                                piece.insert(piece.size(), bpts_pkg::CH_R);
                                piece.insert(piece.size(), bpts_pkg::CH_E);
                            end
                            // near misses: long lead followed by anything
                            7: begin
                                piece.insert(piece.size(), bpts_pkg::CH_L);
                                piece.insert(piece.size(), 8'($urandom_range(0, 255)));
                            end
                            8: begin
                                piece.insert(piece.size(), bpts_pkg::CH_V);
                                piece.insert(piece.size(), 8'($urandom_range(0, 255)));
                            end
                            default: begin
                                piece.insert(piece.size(), bpts_pkg::CH_R);
                                piece.insert(piece.size(), 8'($urandom_range(0, 255)));
                            end
                        endcase
                    end
                    9: piece.insert(piece.size(), bpts_pkg::APOS_CH);
                    default: begin
                        n = $urandom_range(1, 3);
                        repeat (n) piece.insert(piece.size(), 8'($urandom_range(0, 255)));
                    end
                endcase
                foreach (piece[k]) begin
                    if (text_q.size() < seg_len) text_q.insert(text_q.size(), piece[k]);
                end
            end
            foreach (text_q[k]) begin
                row          = '0;
                row.text     = text_q[k];
                row.seg_last = (k == text_q.size() - 1);
                feed.insert(feed.size(), row);
            end
            rand_items += text_q.size();
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Input side: bursts of random length separated by random gaps
        idx        = 0;
        burst_left = 0;
        gap_left   = 0;
        while (idx < feed.size()) begin
            @(posedge aclk);
            if (s_tvalid && s_tready) begin
                split_byte(feed[idx].text, feed[idx].seg_last);
                if (feed[idx].typed) begin
                    pending_chunks.insert(pending_chunks.size(), feed[idx].want);
                end else begin
                    foreach (step_out[k]) pending_chunks.insert(pending_chunks.size(), step_out[k]);
                end
                idx++;
                if (burst_left > 0) burst_left--;
            end
            // a transaction still waiting keeps its values
            if (!(s_tvalid && !s_tready)) begin
                if (idx >= feed.size()) begin
                    s_tvalid <= 1'b0;
                end else begin
                    if (burst_left == 0) begin
                        if ($urandom_range(0, 3) == 0) begin
                            burst_left = $urandom_range(40, 120);
                            gap_left   = 0;
                        end else begin
                            burst_left = $urandom_range(1, 8);
                            gap_left   = $urandom_range(0, 5);
                        end
                    end
                    if (gap_left > 0) begin
                        s_tvalid <= 1'b0;
                        gap_left--;
                    end else begin
                        s_tvalid <= 1'b1;
                        s_tdata  <= feed[idx].text;
                        s_tlast  <= feed[idx].seg_last;
                    end
                end
            end
        end

        // Drain, then wait for anything stray
        while (pending_chunks.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (pending_chunks.size() != 0) fault_cnt++;

        if (fault_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
